/* hdl/brc_pkg.sv */
// Shared types and constants for the banked ROM card.
// Used by every module of the block but brc_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brc_pkg;

  // Bus access codes
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_LATCH  = 3'd2;
  localparam logic [2:0] MODE_RESEAT = 3'd3;
  localparam logic [2:0] MODE_LOAD   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_CHIP_IS_EEPROM   = 3'd0;
  localparam logic [2:0] CFG_WINDOW_IS_ROM16  = 3'd1;
  localparam logic [2:0] CFG_WRITE_ENABLE     = 3'd2;
  localparam logic [2:0] CFG_PAGE_COUNT       = 3'd3;
  localparam logic [2:0] CFG_SIGNATURE_OFFSET = 3'd4;
  localparam logic [2:0] CFG_SIGNATURE_VALUE  = 3'd5;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 15;

  // Byte seen off the window or for anything but a read
  localparam logic [7:0] ROM_BLANK = 8'hFF;

  // Input beat
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] bus_address;
    logic [18:0] load_offset;
    logic [7:0]  data_in;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       firmware_found;
    logic [3:0] current_page;
    logic       current_half;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_cmd;
    logic exec;
    logic scan_rd;
    logic scan_chk;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_reseat;
    logic scan_hit;
    logic scan_last;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

/* hdl/brc_ram.sv */
// Generic single-port RAM with registered read.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module brc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/brc_ctrl.sv */
// Sequencer for the banked ROM card: accept, access, page scan, result.
// Depends on brc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output brc_pkg::ctl_t ctl,
  input  brc_pkg::sts_t sts
);
  import brc_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load_cmd = 1'b1;
          state_next   = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        busy       = 1'b1;
        ctl.exec   = 1'b1;
        state_next = sts.is_reseat ? ST_SCAN_RD : ST_RESP;
      end
      ST_SCAN_RD: begin
        busy        = 1'b1;
        ctl.scan_rd = 1'b1;
        state_next  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        busy         = 1'b1;
        ctl.scan_chk = 1'b1;
        state_next   = (sts.scan_hit || sts.scan_last) ? ST_RESP : ST_SCAN_RD;
      end
      ST_RESP: begin
        // result strobe; the next beat may be taken in the same cycle
        done = 1'b1;
        if (start) begin
          ctl.load_cmd = 1'b1;
          state_next   = ST_ACCESS;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_to_access: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_ACCESS))
    else $error("accepted beat did not enter the access state");

  a_scan_continues: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CHK && !sts.scan_hit && !sts.scan_last) |=> (state == ST_SCAN_RD))
    else $error("page scan stopped early");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");
`endif

endmodule

`default_nettype wire

/* hdl/brc_datapath.sv */
// Datapath of the banked ROM card: config registers, bank latch, address
// mapping, page scan and the ROM store. Depends on brc_pkg and brc_ram.
`timescale 1ns / 1ps
`default_nettype none

module brc_datapath #(
  parameter int unsigned PAGE_BYTES       = 32768,
  parameter int unsigned HALF_BYTES       = 16384,
  parameter int unsigned MAX_PAGES        = 16,
  parameter int unsigned FULL_WINDOW_BASE = 16384,
  parameter int unsigned HALF_WINDOW_BASE = 32768
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  brc_pkg::cmd_t                        cmd,
  input  brc_pkg::ctl_t                        ctl,
  output brc_pkg::sts_t                        sts,
  input  logic                                 cfg_wr,
  input  logic [brc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [brc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output brc_pkg::result_t                     result
);
  import brc_pkg::*;

  localparam int unsigned STORE_BYTES = MAX_PAGES * PAGE_BYTES;
  localparam int unsigned STORE_AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  // wide enough for any mapped offset, the store size and a load offset
  localparam int unsigned OFF_W       = $clog2(16 * PAGE_BYTES + HALF_BYTES + 1);
  localparam int unsigned WIN_W       = 17;

  // Configuration registers
  logic        chip_is_eeprom;
  logic        window_is_rom16;
  logic        write_enable;
  logic [4:0]  page_count;
  logic [14:0] signature_offset;
  logic [7:0]  signature_value;

  // Card state
  logic [7:0]  bank_latch;
  logic [3:0]  boot_page;
  cmd_t        cmd_q;
  logic        rd_hit;
  logic        found;
  logic [3:0]  scan_page;
  logic        scan_ok_q;

  logic [4:0]       pages_used;
  logic [3:0]       page_mask;
  logic [3:0]       eff_page;
  logic             eff_half;
  logic [OFF_W-1:0] limit;
  logic [WIN_W-1:0] win_base;
  logic [WIN_W-1:0] win_size;
  logic [WIN_W-1:0] addr_ext;
  logic [WIN_W-1:0] rel;
  logic             in_win;
  logic [OFF_W-1:0] acc_off;
  logic             map_ok;
  logic [OFF_W-1:0] load_off;
  logic             load_ok;
  logic [OFF_W-1:0] scan_off;
  logic             scan_in;
  logic             is_read, is_write, is_latch, is_reseat, is_load;

  logic                ram_en;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [7:0]          ram_rdata;

  // Page count saturated to 1..MAX_PAGES, latch fields
  always_comb begin
    if (page_count == 5'd0) begin
      pages_used = 5'd1;
    end else if (page_count > 5'(MAX_PAGES)) begin
      pages_used = 5'(MAX_PAGES);
    end else begin
      pages_used = page_count;
    end
  end
  assign page_mask = 4'(pages_used - 5'd1);
  assign eff_page  = bank_latch[3:0] & page_mask;
  assign eff_half  = bank_latch[4];
  assign limit     = OFF_W'(pages_used) * OFF_W'(PAGE_BYTES);

  // Mode decode of the held beat
  assign is_read   = (cmd_q.mode == MODE_READ);
  assign is_write  = (cmd_q.mode == MODE_WRITE);
  assign is_latch  = (cmd_q.mode == MODE_LATCH);
  assign is_reseat = (cmd_q.mode == MODE_RESEAT);
  assign is_load   = (cmd_q.mode == MODE_LOAD);

  // CPU address to store offset
  assign win_base = window_is_rom16 ? WIN_W'(HALF_WINDOW_BASE) : WIN_W'(FULL_WINDOW_BASE);
  assign win_size = window_is_rom16 ? WIN_W'(HALF_BYTES) : WIN_W'(PAGE_BYTES);
  assign addr_ext = {1'b0, cmd_q.bus_address};
  assign rel      = addr_ext - win_base;
  assign in_win   = (addr_ext >= win_base) && (rel < win_size);
  assign acc_off  = OFF_W'(eff_page) * OFF_W'(PAGE_BYTES) + OFF_W'(rel)
                  + ((window_is_rom16 && eff_half) ? OFF_W'(HALF_BYTES) : '0);
  assign map_ok   = in_win && (acc_off < limit) && (acc_off < OFF_W'(STORE_BYTES));

  // Raw load offset
  assign load_off = OFF_W'(cmd_q.load_offset);
  assign load_ok  = (load_off < OFF_W'(STORE_BYTES));

  // Signature location in the page under scan
  assign scan_off = OFF_W'(scan_page) * OFF_W'(PAGE_BYTES) + OFF_W'(signature_offset);
  assign scan_in  = (scan_off < limit) && (scan_off < OFF_W'(STORE_BYTES));

  // Store port
  assign ram_en = (ctl.exec && (is_read || is_write || is_load)) || ctl.scan_rd;
  assign ram_we = ctl.exec && ((is_write && chip_is_eeprom && write_enable && map_ok)
                               || (is_load && load_ok));
  always_comb begin
    if (ctl.scan_rd) begin
      ram_addr = scan_off[STORE_AW-1:0];
    end else if (is_load) begin
      ram_addr = load_off[STORE_AW-1:0];
    end else begin
      ram_addr = acc_off[STORE_AW-1:0];
    end
  end

  brc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd_q.data_in),
    .rdata (ram_rdata)
  );

  // Held beat
  always_ff @(posedge clk) begin
    if (ctl.load_cmd) begin
      cmd_q <= cmd;
    end
  end

  // Config, latch and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_is_eeprom   <= 1'b0;
      window_is_rom16  <= 1'b0;
      write_enable     <= 1'b0;
      page_count       <= 5'd1;
      signature_offset <= 15'd0;
      signature_value  <= 8'd0;
      bank_latch       <= 8'd0;
      boot_page        <= 4'd0;
      rd_hit           <= 1'b0;
      found            <= 1'b0;
      scan_page        <= 4'd0;
      scan_ok_q        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_CHIP_IS_EEPROM:   chip_is_eeprom   <= cfg_data[0];
          CFG_WINDOW_IS_ROM16:  window_is_rom16  <= cfg_data[0];
          CFG_WRITE_ENABLE:     write_enable     <= cfg_data[0];
          CFG_PAGE_COUNT:       page_count       <= cfg_data[4:0];
          CFG_SIGNATURE_OFFSET: signature_offset <= cfg_data[14:0];
          CFG_SIGNATURE_VALUE:  signature_value  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (ctl.exec) begin
        rd_hit <= is_read && map_ok;
        found  <= 1'b0;
        if (is_latch) begin
          bank_latch <= cmd_q.data_in;
        end
        if (is_reseat) begin
          scan_page <= 4'd0;
        end
      end
      if (ctl.scan_rd) begin
        scan_ok_q <= scan_in;
      end
      // first matching page wins; no match points the latch at page zero
      if (ctl.scan_chk) begin
        if (sts.scan_hit) begin
          bank_latch <= {4'd0, scan_page};
          boot_page  <= scan_page;
          found      <= 1'b1;
        end else if (sts.scan_last) begin
          bank_latch <= 8'd0;
          boot_page  <= 4'd0;
        end else begin
          scan_page <= scan_page + 4'd1;
        end
      end
    end
  end

  // Status
  assign sts.is_reseat = is_reseat;
  assign sts.scan_hit  = scan_ok_q && (ram_rdata == signature_value);
  assign sts.scan_last = ({1'b0, scan_page} == (pages_used - 5'd1));

  // Result beat
  assign result.read_data      = rd_hit ? ram_rdata : ROM_BLANK;
  assign result.firmware_found = found;
  assign result.current_page   = eff_page;
  assign result.current_half   = eff_half;

`ifndef NO_ASSERTIONS
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_rd |-> ({1'b0, scan_page} < pages_used))
    else $error("scan beyond the pages in use");

  a_hit_sets_latch: assert property (@(posedge clk) disable iff (rst)
    (ctl.scan_chk && sts.scan_hit) |=>
      (found && boot_page == bank_latch[3:0] && bank_latch[7:4] == 4'd0))
    else $error("re-seat hit did not point latch at the boot page");

  a_found_not_read: assert property (@(posedge clk) disable iff (rst)
    found |-> !rd_hit)
    else $error("read hit and firmware found together");
`endif

endmodule

`default_nettype wire

/* hdl/banked_rom_card.sv */
// Top level of the banked ROM card: sequencer plus datapath.
// Depends on brc_pkg, brc_ctrl, brc_datapath (and brc_ram below it).
//
//  channel   handshake                 payload                 direction
//  -------   -----------------------   ---------------------   ---------
//  command   start / busy              cmd   (cmd_t)           in
//  result    done (one-cycle strobe)   result (result_t)       out
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data     in
//
// Read, write, latch and load beats pass through a store access state, then
// the result state, in which the next start is already taken.
// Re-seat examines the pages in order, up to the page count, until a hit:
// each page costs a read and a compare on the single store port.
// rst is synchronous, active high; the store itself is not cleared.
// Results cannot be held off: done marks the one cycle they are valid.
`timescale 1ns / 1ps
`default_nettype none

module banked_rom_card #(
  parameter int unsigned PAGE_BYTES       = 32768,
  parameter int unsigned HALF_BYTES       = 16384,
  parameter int unsigned MAX_PAGES        = 16,
  parameter int unsigned FULL_WINDOW_BASE = 16384,
  parameter int unsigned HALF_WINDOW_BASE = 32768
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  brc_pkg::cmd_t                    cmd,
  output logic                             done,
  output brc_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [brc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [brc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import brc_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic cfg_wr;

  // Config beats are taken whenever no access is in flight
  assign cfg_ready = ~busy;
  assign cfg_wr    = cfg_valid & cfg_ready;

  brc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl),
    .sts   (sts)
  );

  brc_datapath #(
    .PAGE_BYTES       (PAGE_BYTES),
    .HALF_BYTES       (HALF_BYTES),
    .MAX_PAGES        (MAX_PAGES),
    .FULL_WINDOW_BASE (FULL_WINDOW_BASE),
    .HALF_WINDOW_BASE (HALF_WINDOW_BASE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for banked_rom_card: directed and random bus beats against a
// built-in card predictor. Depends on brc_pkg and the banked_rom_card RTL only.
`timescale 1ns / 1ps

module tb;

  import brc_pkg::*;

  // Card geometry, matching the defaults of the block
  localparam int unsigned PAGE_BYTES       = 32768;
  localparam int unsigned HALF_BYTES       = 16384;
  localparam int unsigned MAX_PAGES        = 16;
  localparam int unsigned FULL_WINDOW_BASE = 16384;
  localparam int unsigned HALF_WINDOW_BASE = 32768;
  localparam int unsigned STORE_BYTES      = PAGE_BYTES * MAX_PAGES;

  // Codes the package leaves unnamed
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [2:0] CFG_SPARE_INDEX  = 3'd7;

  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned BEATS_PER_PHASE = 250;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  cmd_t                   cmd = '0;
  logic                   done;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  banked_rom_card #(
    .PAGE_BYTES       (PAGE_BYTES),
    .HALF_BYTES       (HALF_BYTES),
    .MAX_PAGES        (MAX_PAGES),
    .FULL_WINDOW_BASE (FULL_WINDOW_BASE),
    .HALF_WINDOW_BASE (HALF_WINDOW_BASE)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Card shadow: store contents, which entries hold data, latch and setup
  bit [7:0]  rom_image [STORE_BYTES];
  bit        rom_known [STORE_BYTES];
  bit [7:0]  bank_latch_m;
  bit [3:0]  boot_page_m;
  bit        cfg_eeprom;
  bit        cfg_rom16;
  bit        cfg_we;
  bit [4:0]  cfg_pages = 5'd1;
  bit [14:0] cfg_sig_off;
  bit [7:0]  cfg_sig_val;

  // Predicted replies, oldest first
  result_t     card_reply_q[$];
  result_t     want;
  int          replies_owed;
  int unsigned reply_errors;
  int unsigned beats_sent;
  int unsigned reads_sent;
  int unsigned reseats_sent;
  int unsigned boots_found;
  int unsigned setups_done;
  int unsigned steady_left;

  // ---------------------------------------------------------------------------
  // Card predictor
  // ---------------------------------------------------------------------------

  // Zero and oversize page counts are clamped
  function automatic int unsigned pages_used();
    int unsigned n;
    n = cfg_pages;
    if (n == 0) n = 1;
    if (n > MAX_PAGES) n = MAX_PAGES;
    return n;
  endfunction

  function automatic bit [3:0] shown_page();
    return bank_latch_m[3:0] & 4'(pages_used() - 1);
  endfunction

  // CPU address to store index; 0 when nothing of the store is seen there
  function automatic bit map_bus(input logic [15:0] addr, output int unsigned idx);
    int unsigned base;
    int unsigned span;
    int unsigned off;
    base = cfg_rom16 ? HALF_WINDOW_BASE : FULL_WINDOW_BASE;
    span = cfg_rom16 ? HALF_BYTES : PAGE_BYTES;
    idx = 0;
    if (addr < base || addr - base >= span) return 1'b0;
    off = int'(shown_page()) * PAGE_BYTES + (addr - base);
    if (cfg_rom16) off += int'(bank_latch_m[4]) * HALF_BYTES;
    if (off >= pages_used() * PAGE_BYTES) return 1'b0;
    idx = off;
    return 1'b1;
  endfunction

  // One bus beat: updates the shadow and returns the reply the card owes
  function automatic result_t card_access(input cmd_t c);
    result_t     r;
    int unsigned idx;
    int unsigned pg;
    bit          hit;
    r.read_data      = ROM_BLANK;
    r.firmware_found = 1'b0;
    hit = 1'b0;
    case (c.mode)
      MODE_READ: begin
        if (map_bus(c.bus_address, idx)) r.read_data = rom_image[idx];
      end
      MODE_WRITE: begin
        if (cfg_eeprom && cfg_we) begin
          if (map_bus(c.bus_address, idx)) begin
            rom_image[idx] = c.data_in;
            rom_known[idx] = 1'b1;
          end
        end
      end
      MODE_LATCH: bank_latch_m = c.data_in;
      MODE_RESEAT: begin
        // first page carrying the signature wins
        pg = 0;
        while (!hit && pg < pages_used()) begin
          if (rom_image[pg * PAGE_BYTES + cfg_sig_off] == cfg_sig_val) hit = 1'b1;
          else pg++;
        end
        boot_page_m      = hit ? 4'(pg) : 4'd0;
        bank_latch_m     = hit ? 8'(pg) : 8'd0;
        r.firmware_found = hit;
      end
      MODE_LOAD: begin
        rom_image[c.load_offset] = c.data_in;
        rom_known[c.load_offset] = 1'b1;
      end
      default: ;
    endcase
    r.current_page = shown_page();
    r.current_half = bank_latch_m[4];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat and register drivers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones, now and then a run with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cmd_t make_access(input logic [2:0] mode, input logic [15:0] addr,
                                       input logic [18:0] loff, input logic [7:0] data);
    cmd_t c;
    c.mode        = mode;
    c.bus_address = addr;
    c.load_offset = loff;
    c.data_in     = data;
    return c;
  endfunction

  // Present one beat, wait for it to be taken, then queue its reply
  task automatic drive_beat(input cmd_t c);
    int unsigned gap;
    result_t     r;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    r = card_access(c);
    card_reply_q.push_back(r);
    replies_owed++;
    beats_sent++;
    if (c.mode == MODE_READ) reads_sent++;
    if (c.mode == MODE_RESEAT) begin
      reseats_sent++;
      if (r.firmware_found) boots_found++;
    end
  endtask

  // Store entries are undefined until loaded: fill any a beat would read first
  task automatic send_access(input cmd_t c);
    int unsigned idx;
    int unsigned pg;
    if (c.mode == MODE_READ) begin
      if (map_bus(c.bus_address, idx)) begin
        if (!rom_known[idx])
          drive_beat(make_access(MODE_LOAD, 16'($urandom), 19'(idx), 8'($urandom)));
      end
    end
    if (c.mode == MODE_RESEAT) begin
      for (pg = 0; pg < pages_used(); pg++) begin
        idx = pg * PAGE_BYTES + cfg_sig_off;
        if (!rom_known[idx])
          drive_beat(make_access(MODE_LOAD, 16'($urandom), 19'(idx),
                                 ($urandom_range(0, 3) == 0) ? cfg_sig_val : 8'($urandom)));
      end
    end
    drive_beat(c);
  endtask

  task automatic read_at(input logic [15:0] addr);
    send_access(make_access(MODE_READ, addr, 19'($urandom), 8'($urandom)));
  endtask

  task automatic write_at(input logic [15:0] addr, input logic [7:0] data);
    send_access(make_access(MODE_WRITE, addr, 19'($urandom), data));
  endtask

  task automatic load_at(input logic [18:0] loff, input logic [7:0] data);
    send_access(make_access(MODE_LOAD, 16'($urandom), loff, data));
  endtask

  task automatic set_latch(input logic [7:0] data);
    send_access(make_access(MODE_LATCH, 16'($urandom), 19'($urandom), data));
  endtask

  task automatic reseat_now();
    send_access(make_access(MODE_RESEAT, 16'($urandom), 19'($urandom), 8'($urandom)));
  endtask

  // Drop start and wait until every owed reply has come back
  task automatic settle();
    start <= 1'b0;
    wait (replies_owed == 0);
    @(posedge clk);
  endtask

  // Leaves valid high so back-to-back register beats need no re-raise
  task automatic write_reg(input logic [2:0] idx, input logic [14:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CHIP_IS_EEPROM:   cfg_eeprom  = value[0];
      CFG_WINDOW_IS_ROM16:  cfg_rom16   = value[0];
      CFG_WRITE_ENABLE:     cfg_we      = value[0];
      CFG_PAGE_COUNT:       cfg_pages   = value[4:0];
      CFG_SIGNATURE_OFFSET: cfg_sig_off = value;
      CFG_SIGNATURE_VALUE:  cfg_sig_val = value[7:0];
      default: ;
    endcase
  endtask

  // Rewrites every register once the card is idle; unused upper bits carry junk
  task automatic write_setup(input bit eeprom, input bit rom16, input bit we,
                             input bit [4:0] pages, input bit [14:0] sig_off,
                             input bit [7:0] sig_val);
    logic [14:0] junk;
    settle();
    junk = $urandom_range(0, 1) ? 15'($urandom) : 15'd0;
    write_reg(CFG_CHIP_IS_EEPROM,   {junk[14:1], eeprom});
    write_reg(CFG_WINDOW_IS_ROM16,  {junk[14:1], rom16});
    write_reg(CFG_WRITE_ENABLE,     {junk[14:1], we});
    write_reg(CFG_PAGE_COUNT,       {junk[14:5], pages});
    write_reg(CFG_SIGNATURE_OFFSET, sig_off);
    write_reg(CFG_SIGNATURE_VALUE,  {junk[14:8], sig_val});
    if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_INDEX, 15'($urandom));
    cfg_valid <= 1'b0;
    setups_done++;
  endtask

  // ---------------------------------------------------------------------------
  // Reply checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && done) begin
      if (card_reply_q.size() == 0) begin
        $error("reply with no beat outstanding");
        reply_errors++;
      end else begin
        want = card_reply_q.pop_front();
        replies_owed--;
        if (result.read_data !== want.read_data) begin
          $error("read_data: expected %02h, got %02h", want.read_data, result.read_data);
          reply_errors++;
        end
        if (result.firmware_found !== want.firmware_found) begin
          $error("firmware_found: expected %0d, got %0d",
                 want.firmware_found, result.firmware_found);
          reply_errors++;
        end
        if (result.current_page !== want.current_page) begin
          $error("current_page: expected %0d, got %0d", want.current_page, result.current_page);
          reply_errors++;
        end
        if (result.current_half !== want.current_half) begin
          $error("current_half: expected %0d, got %0d", want.current_half, result.current_half);
          reply_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setup: flash, full window, one page; window edges and outside reads
  task automatic test_window_mapping();
    load_at(19'h00000, 8'h5A);
    load_at(19'h07FFF, 8'hA5);
    load_at(19'h7FFFF, 8'h3C);
    read_at(16'h4000);
    read_at(16'hBFFF);
    read_at(16'h3FFF);
    read_at(16'hC000);
  endtask

  // Writes land only on an EEPROM with the jumper set, and only in the window
  task automatic test_write_protect();
    write_at(16'h4000, 8'h11);
    read_at(16'h4000);
    write_setup(1'b1, 1'b0, 1'b0, 5'd1, 15'd0, 8'd0);
    write_at(16'h4000, 8'h22);
    read_at(16'h4000);
    write_setup(1'b1, 1'b0, 1'b1, 5'd1, 15'd0, 8'd0);
    write_at(16'h4000, 8'h33);
    read_at(16'h4000);
    write_at(16'h3FFF, 8'h44);
  endtask

  // Oversize, odd and zero page counts; half select from latch bit 4
  task automatic test_page_masking();
    write_setup(1'b1, 1'b1, 1'b1, 5'd31, 15'd0, 8'd0);
    set_latch(8'hFF);
    read_at(16'h8000);
    read_at(16'hBFFF);
    read_at(16'h7FFF);
    write_setup(1'b1, 1'b1, 1'b1, 5'd3, 15'd0, 8'd0);
    set_latch(8'h07);
    write_setup(1'b0, 1'b0, 1'b0, 5'd0, 15'd0, 8'd0);
    set_latch(8'h1F);
    send_access(make_access(MODE_SPARE_LAST, 16'hFFFF, 19'h7FFFF, 8'hFF));
  endtask

  // Signature at the last byte of each page: hit, later hit, first page, none
  task automatic test_boot_reseat();
    write_setup(1'b1, 1'b0, 1'b1, 5'd4, 15'h7FFF, 8'hFF);
    load_at(19'(0 * PAGE_BYTES + 32'h7FFF), 8'h00);
    load_at(19'(1 * PAGE_BYTES + 32'h7FFF), 8'h7F);
    load_at(19'(2 * PAGE_BYTES + 32'h7FFF), 8'hFF);
    load_at(19'(3 * PAGE_BYTES + 32'h7FFF), 8'hFF);
    reseat_now();
    load_at(19'(2 * PAGE_BYTES + 32'h7FFF), 8'hFE);
    reseat_now();
    write_setup(1'b1, 1'b0, 1'b1, 5'd4, 15'h7FFF, 8'h00);
    reseat_now();
    write_setup(1'b1, 1'b0, 1'b1, 5'd4, 15'h7FFF, 8'h55);
    reseat_now();
  endtask

  // Address near the window edges, inside it, or anywhere
  function automatic logic [15:0] pick_bus_address();
    int unsigned base;
    int unsigned span;
    base = cfg_rom16 ? HALF_WINDOW_BASE : FULL_WINDOW_BASE;
    span = cfg_rom16 ? HALF_BYTES : PAGE_BYTES;
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'(base + $urandom_range(0, 31));
      3, 4:    return 16'(base + span - 1 - $urandom_range(0, 31));
      5:       return 16'(base + $urandom_range(0, span - 1));
      6, 7: begin
        case ($urandom_range(0, 5))
          0:       return 16'(base - 1);
          1:       return 16'(base);
          2:       return 16'(base + span - 1);
          3:       return 16'(base + span);
          4:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Loads mostly aim where reads and re-seats will look
  function automatic logic [18:0] pick_load_offset();
    int unsigned page_base;
    if ($urandom_range(0, 3) == 0) page_base = $urandom_range(0, MAX_PAGES - 1) * PAGE_BYTES;
    else page_base = $urandom_range(0, pages_used() - 1) * PAGE_BYTES;
    case ($urandom_range(0, 9))
      0, 1:    return 19'(page_base + $urandom_range(0, 31));
      2:       return 19'(page_base + HALF_BYTES - 16 + $urandom_range(0, 31));
      3:       return 19'(page_base + PAGE_BYTES - 1 - $urandom_range(0, 31));
      4, 5:    return 19'(page_base + cfg_sig_off);
      default: return 19'($urandom);
    endcase
  endfunction

  function automatic cmd_t random_access();
    cmd_t        c;
    int unsigned r;
    c = make_access(MODE_READ, 16'($urandom), 19'($urandom), 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 34) begin
      c.bus_address = pick_bus_address();
    end else if (r < 52) begin
      c.mode        = MODE_WRITE;
      c.bus_address = pick_bus_address();
    end else if (r < 64) begin
      c.mode = MODE_LATCH;
      if ($urandom_range(0, 2) != 0) c.data_in = 8'($urandom_range(0, 31));
    end else if (r < 69) begin
      c.mode = MODE_RESEAT;
    end else if (r < 96) begin
      c.mode        = MODE_LOAD;
      c.load_offset = pick_load_offset();
      if ($urandom_range(0, 9) == 0) c.data_in = cfg_sig_val;
    end else begin
      c.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    end
    return c;
  endfunction

  // Mostly powers of two, sometimes any 5-bit count
  function automatic bit [4:0] pick_page_count();
    if ($urandom_range(0, 9) < 7) return 5'(1 << $urandom_range(0, 4));
    return 5'($urandom_range(0, 31));
  endfunction

  // Random traffic over several setups, the extremes first
  task automatic test_random_traffic();
    int unsigned ph;
    bit [14:0]   sig_off;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_setup(1'b1, 1'b0, 1'b1, 5'd16, 15'h7FFF, 8'hFF);
        1: write_setup(1'b1, 1'b1, 1'b1, 5'd1, 15'd0, 8'd0);
        2: write_setup(1'b0, 1'b1, 1'b0, 5'd31, 15'h4000, 8'($urandom));
        default: begin
          case ($urandom_range(0, 3))
            0:       sig_off = 15'd0;
            1:       sig_off = 15'h7FFF;
            default: sig_off = 15'($urandom);
          endcase
          write_setup($urandom_range(0, 3) != 0, $urandom_range(0, 1), $urandom_range(0, 3) != 0,
                      pick_page_count(), sig_off, 8'($urandom));
        end
      endcase
      repeat (BEATS_PER_PHASE) send_access(random_access());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_window_mapping();
    test_write_protect();
    test_page_masking();
    test_boot_reseat();
    test_random_traffic();
    settle();
    repeat (4) @(posedge clk);
    $display("Ran %0d beats: %0d reads, %0d re-seats (%0d found firmware),", beats_sent,
             reads_sent, reseats_sent, boots_found);
    $display("over %0d register setups, %0d reply mismatches.", setups_done, reply_errors);
    if (reply_errors == 0 && card_reply_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, many times the slowest legal run
  initial begin
    #40_000_000;
    $display("Timed out with %0d replies outstanding", replies_owed);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* banked_rom_card.f */
hdl/brc_pkg.sv
hdl/brc_ram.sv
hdl/brc_ctrl.sv
hdl/brc_datapath.sv
hdl/banked_rom_card.sv
tb/tb.sv
